FILE: sv/rgbc_lux_chromaticity_cct_defines.svh
// Assertion macros shared by the RTL of the RGBC conversion block.
`ifndef RGBC_LUX_CHROMATICITY_CCT_DEFINES_SVH
`define RGBC_LUX_CHROMATICITY_CCT_DEFINES_SVH
`ifndef SYNTHESIS
`define RLCC_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error("rlcc check failed");
`define RLCC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error("rlcc check failed");
`else
`define RLCC_ASSERT(lbl, ck, rn, prop)
`define RLCC_ASSERT_IMP(lbl, ck, rn, ante, cons)
`endif
`endif

FILE: sv/rlcc_pkg.sv
`default_nettype none
package rlcc_pkg;

  localparam int CH_W = 16;
  localparam int CW   = 18;            // chromaticity output width
  localparam int QX   = 18;            // quotient bits of the x and y division
  localparam int QN   = 20;            // quotient bits of the McCamy ratio
  localparam int PW   = 35;            // matrix product width
  localparam int VW   = 37;            // matrix row sum width
  localparam int AW   = 33;            // magnitude of a row sum
  localparam int SW   = 34;            // XYZ sum as divisor
  localparam int LPW  = 36;            // lux product width
  localparam int NMW  = 37;            // lux numerator width
  localparam int NW   = 22;            // McCamy numerator and denominator
  localparam int NNW  = 21;            // signed ratio n, Q16

  localparam logic signed [17:0] XYZ_MAT [9] = '{
    -18'sd9360,  18'sd101531, -18'sd62679,
    -18'sd21277, 18'sd103440, -18'sd47966,
    -18'sd44697, 18'sd50511,   18'sd36918
  };

  localparam logic signed [17:0] LUX_C1 = 18'sd8913;
  localparam logic signed [17:0] LUX_R1 = 18'sd27591;
  localparam logic signed [17:0] LUX_C2 = 18'sd15401;
  localparam logic signed [17:0] LUX_B2 = 18'sd33751;
  localparam logic [11:0] LUX_NUM       = 12'd3100;
  localparam logic [22:0] LUX_SAT       = 23'd4128768;
  localparam logic [23:0] LUX_RECIP     = 24'd8521761;

  localparam logic signed [VW-1:0] SUM_MIN = VW'(65536);

  localparam logic signed [CW-1:0] CH_MAX = 18'sd131071;
  localparam logic signed [CW-1:0] CH_MIN = -18'sd131072;

  localparam logic [QN-1:0] N_NEG_MAG = 20'd524288;
  localparam logic [QN-1:0] N_POS_MAG = 20'd131072;

  localparam logic signed [29:0] CCT_A1 = 30'sd447171789;
  localparam logic signed [12:0] CCT_A2 = 13'sd3525;
  localparam logic signed [10:0] CCT_A3 = 11'sd449;
  localparam logic signed [39:0] CCT_A0 = 40'sd361780347;
  localparam logic signed [39:0] CCT_MIN = 40'sd65536000;
  localparam logic signed [39:0] CCT_MAX = 40'sd786432000;
  localparam logic [13:0] TEMP_MIN_K = 14'd1000;

  typedef struct packed {
    logic                 lux_valid;
    logic                 ch_ok;
    logic                 xneg;
    logic                 yneg;
    logic                 nneg;
    logic                 ndz;
    logic                 n_ok;
    logic [15:0]          lux;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } pk_t;

  function automatic logic signed [CW-1:0] sat_q(input logic neg, input logic ovf,
                                                 input logic [QX-1:0] q);
    logic signed [QX:0] nq;
    nq = -$signed({1'b0, q});
    if (!neg) begin
      sat_q = (ovf || q[QX-1]) ? CH_MAX : $signed({1'b0, q[QX-2:0]});
    end else begin
      sat_q = (ovf || q > QX'(131072)) ? CH_MIN : nq[CW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/rlcc_div.sv
`default_nettype none
module rlcc_div #(
  parameter int DW = 40,
  parameter int SW = 34,
  parameter int QW = 18
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] dvd,
  input  wire logic [SW-1:0] dvs,
  output logic [QW-1:0]      quo,
  output logic               ovf
);

  localparam int RW = ((DW > SW + QW) ? DW : SW + QW) + 1;

  logic [RW-1:0] rem_r [0:QW-1];
  logic [SW-1:0] dvs_r [0:QW-1];
  logic [QW-1:0] q_r   [0:QW];
  logic          ovf_r [0:QW];

  // Stage zero flags quotients that do not fit in QW bits.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(dvd);
      dvs_r[0] <= dvs;
      q_r[0]   <= '0;
      ovf_r[0] <= RW'(dvd) >= (RW'(dvs) << QW);
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_st
    localparam int K = QW - j;
    logic [RW-1:0] shd;
    logic          ge;
    assign shd = RW'(dvs_r[j-1]) << K;
    assign ge  = rem_r[j-1] >= shd;
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j]   <= q_r[j-1] | (ge ? (QW'(1) << K) : '0);
        ovf_r[j] <= ovf_r[j-1];
      end
    end
    if (j < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? rem_r[j-1] - shd : rem_r[j-1];
          dvs_r[j] <= dvs_r[j-1];
        end
      end
    end
  end

  assign quo = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule
`default_nettype wire

FILE: sv/rgbc_lux_chromaticity_cct.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    in_red, in_green, in_blue, in_clear
// out      output     out_valid / out_stall  out_lux, out_lux_valid, out_chroma_x,
//                                            out_chroma_y, out_chroma_valid,
//                                            out_color_temp, out_temp_valid
//
// One transaction enters per cycle while the output is not stalled.
// Most of the pipeline depth lies in the restoring dividers, one quotient bit per stage
// (18 stages for x and y, 20 for the McCamy ratio), plus the multiply stages.
// Reset clears only the valid bits of the pipeline; input is taken once rst_n is high.
// A stall at the output while out_valid is high freezes every stage and back-pressures the input.
`default_nettype none
`include "rgbc_lux_chromaticity_cct_defines.svh"
module rgbc_lux_chromaticity_cct #(
  parameter int CHROMA_FRAC_BITS = 14
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rlcc_pkg::CH_W-1:0]     in_red,
  input  wire logic [rlcc_pkg::CH_W-1:0]     in_green,
  input  wire logic [rlcc_pkg::CH_W-1:0]     in_blue,
  input  wire logic [rlcc_pkg::CH_W-1:0]     in_clear,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [15:0]                        out_lux,
  output logic                               out_lux_valid,
  output logic signed [rlcc_pkg::CW-1:0]     out_chroma_x,
  output logic signed [rlcc_pkg::CW-1:0]     out_chroma_y,
  output logic                               out_chroma_valid,
  output logic [13:0]                        out_color_temp,
  output logic                               out_temp_valid
);
  import rlcc_pkg::*;

  localparam int     F   = CHROMA_FRAC_BITS;
  localparam int     DXW = AW + F;
  localparam longint X0  = (longint'(3320) * (longint'(1) << F) + 5000) / 10000;
  localparam longint Y0  = (longint'(1858) * (longint'(1) << F) + 5000) / 10000;

  localparam int ST_SUM  = 4;
  localparam int ST_LUX  = 7;
  localparam int ST_XYDV = ST_SUM + 1 + QX;
  localparam int ST_XY   = ST_XYDV + 1;
  localparam int ST_NND  = ST_XY + 1;
  localparam int ST_NDV  = ST_NND + 1 + QN;
  localparam int ST_N    = ST_NDV + 1;
  localparam int ST_CCT  = ST_N + 3;
  localparam int NST     = ST_CCT + 1;

  logic           en;
  logic [NST:1]   vld_r;
  pk_t            pk_r [1:ST_CCT];
  pk_t            pk_nxt [1:ST_CCT];
  pk_t            pk_in;

  assign en        = !vld_r[NST] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld_r[NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-1:1], in_valid};
    end
  end

  always_comb begin
    pk_in           = '0;
    pk_in.lux_valid = |in_clear;
  end

  // Stage 1: input registers.
  logic [CH_W-1:0] r1_r, g1_r, b1_r, c1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      r1_r <= in_red;
      g1_r <= in_green;
      b1_r <= in_blue;
      c1_r <= in_clear;
    end
  end

  // Stage 2: IR removal and matrix products.
  logic [CH_W-1:0]        rgb1 [3];
  logic signed [18:0]     irs;
  logic [16:0]            ir;
  logic signed [17:0]     ci2_r, ri2_r, bi2_r;
  logic signed [PW-1:0]   mp_r [9];

  assign rgb1[0] = r1_r;
  assign rgb1[1] = g1_r;
  assign rgb1[2] = b1_r;

  always_comb begin
    irs = $signed({3'b0, r1_r}) + $signed({3'b0, g1_r}) + $signed({3'b0, b1_r})
        - $signed({3'b0, c1_r});
    ir  = (irs > 0) ? irs[17:1] : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ci2_r <= $signed({2'b0, c1_r}) - $signed({1'b0, ir});
      ri2_r <= $signed({2'b0, r1_r}) - $signed({1'b0, ir});
      bi2_r <= $signed({2'b0, b1_r}) - $signed({1'b0, ir});
      for (int k = 0; k < 9; k++) begin
        mp_r[k] <= PW'(XYZ_MAT[k]) * PW'($signed({1'b0, rgb1[k % 3]}));
      end
    end
  end

  // Stage 3: XYZ rows and lux products.
  logic signed [VW-1:0]  v_r [3];
  logic signed [LPW-1:0] lp_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        v_r[k] <= VW'(mp_r[3*k]) + VW'(mp_r[3*k+1]) + VW'(mp_r[3*k+2]);
      end
      lp_r[0] <= LPW'(LUX_C1) * LPW'(ci2_r);
      lp_r[1] <= LPW'(LUX_R1) * LPW'(ri2_r);
      lp_r[2] <= LPW'(LUX_C2) * LPW'(ci2_r);
      lp_r[3] <= LPW'(LUX_B2) * LPW'(bi2_r);
    end
  end

  // Stage 4: XYZ sum, magnitudes, larger lux numerator.
  logic signed [VW-1:0]  sum_nxt, av0, av1;
  logic signed [NMW-1:0] n1, n2;
  logic [SW-1:0]         sum_r;
  logic [AW-1:0]         ax_r, ay_r;
  logic signed [NMW-1:0] nm_r;

  always_comb begin
    sum_nxt = v_r[0] + v_r[1] + v_r[2];
    av0     = v_r[0][VW-1] ? -v_r[0] : v_r[0];
    av1     = v_r[1][VW-1] ? -v_r[1] : v_r[1];
    n1      = NMW'(lp_r[0]) - NMW'(lp_r[1]);
    n2      = NMW'(lp_r[2]) - NMW'(lp_r[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt[SW-1:0];
      ax_r  <= av0[AW-1:0];
      ay_r  <= av1[AW-1:0];
      nm_r  <= (n1 > n2) ? n1 : n2;
    end
  end

  // Stages 5 to 7: lux = nm * 3100 / (2016 * 2^16), divide by 63 via reciprocal.
  logic [43:0] a5_r;
  logic [22:0] m6;
  logic        sat6_r;
  logic [45:0] lp6_r;
  assign m6 = a5_r[43:21];
  always_ff @(posedge clk) begin
    if (en) begin
      a5_r   <= (nm_r > 0) ? 44'(nm_r[31:0]) * 44'(LUX_NUM) : '0;
      sat6_r <= m6 >= LUX_SAT;
      lp6_r  <= 46'(m6[21:0]) * 46'(LUX_RECIP);
    end
  end

  // Chromaticity dividers.
  logic [QX-1:0] qx, qy;
  logic          ovx, ovy;

  rlcc_div #(.DW(DXW), .SW(SW), .QW(QX)) u_div_x (
    .clk (clk), .en (en), .dvd ({ax_r, {F{1'b0}}}), .dvs (sum_r), .quo (qx), .ovf (ovx)
  );
  rlcc_div #(.DW(DXW), .SW(SW), .QW(QX)) u_div_y (
    .clk (clk), .en (en), .dvd ({ay_r, {F{1'b0}}}), .dvs (sum_r), .quo (qy), .ovf (ovy)
  );

  // McCamy numerator and denominator.
  logic signed [NW-1:0] nn, nd, ann, and_v;
  logic [NW-2:0]        ann_r, and_r;
  always_comb begin
    nn    = NW'(pk_r[ST_XY].x) - NW'(X0);
    nd    = NW'(Y0) - NW'(pk_r[ST_XY].y);
    ann   = nn[NW-1] ? -nn : nn;
    and_v = nd[NW-1] ? -nd : nd;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ann_r <= ann[NW-2:0];
      and_r <= and_v[NW-2:0];
    end
  end

  logic [QN-1:0] qn;
  logic          ovn;
  rlcc_div #(.DW(NW - 1 + 16), .SW(NW - 1), .QW(QN)) u_div_n (
    .clk (clk), .en (en), .dvd ({ann_r, 16'b0}), .dvs (and_r), .quo (qn), .ovf (ovn)
  );

  // Cubic in n, Q16, each product truncated toward zero.
  logic signed [NNW-1:0] n_r, n48_r;
  logic signed [41:0]    sq;
  logic signed [50:0]    tp, tpb;
  logic signed [23:0]    n2_r, n249_r;
  logic signed [34:0]    t_r, t49_r;
  logic signed [44:0]    p3, p3b;
  logic signed [28:0]    n3_r;
  logic signed [39:0]    cct_r;

  always_comb begin
    sq  = 42'(n_r) * 42'(n_r);
    tp  = 51'(CCT_A1) * 51'(n_r);
    tpb = tp + (tp[50] ? 51'sd65535 : 51'sd0);
    p3  = 45'(n2_r) * 45'(n48_r);
    p3b = p3 + (p3[44] ? 45'sd65535 : 45'sd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= pk_r[ST_NDV].nneg ? -NNW'({1'b0, qn}) : NNW'({1'b0, qn});
      n2_r   <= $signed({1'b0, sq[38:16]});
      t_r    <= tpb[50:16];
      n48_r  <= n_r;
      n3_r   <= p3b[44:16];
      n249_r <= n2_r;
      t49_r  <= t_r;
      cct_r  <= 40'(n3_r) * 40'(CCT_A3) + 40'(n249_r) * 40'(CCT_A2) + 40'(t49_r) + CCT_A0;
    end
  end

  // Side information travels with each transaction.
  always_comb begin
    pk_nxt[1] = pk_in;
    for (int i = 2; i <= ST_CCT; i++) begin
      pk_nxt[i] = pk_r[i-1];
    end
    pk_nxt[ST_SUM].ch_ok = sum_nxt >= SUM_MIN;
    pk_nxt[ST_SUM].xneg  = v_r[0][VW-1];
    pk_nxt[ST_SUM].yneg  = v_r[1][VW-1];
    pk_nxt[ST_LUX].lux   = sat6_r ? 16'hFFFF : lp6_r[44:29];
    pk_nxt[ST_XY].x      = sat_q(pk_r[ST_XYDV].xneg, ovx, qx);
    pk_nxt[ST_XY].y      = sat_q(pk_r[ST_XYDV].yneg, ovy, qy);
    pk_nxt[ST_NND].nneg  = nn[NW-1] ^ nd[NW-1];
    pk_nxt[ST_NND].ndz   = nd == '0;
    pk_nxt[ST_N].n_ok    = !ovn && (pk_r[ST_NDV].nneg ? (qn <= N_NEG_MAG)
                                                      : (qn <= N_POS_MAG));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 1; i <= ST_CCT; i++) begin
        pk_r[i] <= pk_nxt[i];
      end
    end
  end

  // Output register.
  pk_t  pf;
  logic cv, tv;
  always_comb begin
    pf = pk_r[ST_CCT];
    cv = pf.lux_valid && pf.ch_ok;
    tv = cv && !pf.ndz && pf.n_ok && (cct_r >= CCT_MIN) && (cct_r <= CCT_MAX);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lux          <= pf.lux_valid ? pf.lux : '0;
      out_lux_valid    <= pf.lux_valid;
      out_chroma_x     <= cv ? pf.x : '0;
      out_chroma_y     <= cv ? pf.y : '0;
      out_chroma_valid <= cv;
      out_color_temp   <= tv ? cct_r[29:16] : '0;
      out_temp_valid   <= tv;
    end
  end

  `RLCC_ASSERT(a_hold_on_stall, clk, rst_n, !en |=> $stable(vld_r))
  `RLCC_ASSERT_IMP(a_err_zeroes, clk, rst_n, out_valid && !out_lux_valid, out_lux == '0 && !out_chroma_valid && !out_temp_valid)
  `RLCC_ASSERT_IMP(a_chroma_needs_lux, clk, rst_n, out_valid && out_chroma_valid, out_lux_valid)
  `RLCC_ASSERT_IMP(a_temp_range, clk, rst_n, out_valid && out_temp_valid, out_chroma_valid && out_color_temp >= TEMP_MIN_K)

endmodule
`default_nettype wire
